>>> src/v3n_pkg.sv
package v3n_pkg;

  // Number of register stages from input transfer to result register
  localparam int unsigned NumStages = 9;

  localparam logic [31:0] RsqrtMagic = 32'h5f3759df;
  localparam logic [31:0] QNan       = 32'h7FC00000;
  localparam logic [31:0] OneHalf    = 32'h3F000000;
  localparam logic [31:0] ThreeHalf  = 32'h3FC00000;

  // Per-stage payload: carried components and working operands
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] e;
  } stg_t;

  // Leading-zero count over a 50-bit word
  function automatic logic [5:0] fp_lz(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack; m has its leading one at bit 49
  function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                           input logic [49:0] m);
    logic [99:0] w;
    logic [10:0] sh;
    logic [49:0] m2;
    logic [7:0]  ex;
    logic [23:0] mt;
    logic        st;
    logic        g;
    logic        up;
    logic [30:0] comb;
    st = 1'b0;
    w  = '0;
    sh = '0;
    if (e >= 11'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    if (e <= 11'sd0) begin
      sh = 11'(11'sd1 - e);
      if (sh > 11'd50) sh = 11'd50;
      w  = {m, 50'd0} >> sh;
      m2 = w[99:50];
      st = |w[49:0];
      ex = 8'd0;
    end else begin
      m2 = m;
      ex = e[7:0];
    end
    mt   = m2[49:26];
    g    = m2[25];
    st   = st | (|m2[24:0]);
    up   = g && (st || mt[0]);
    comb = {ex, mt[22:0]} + {30'd0, up};
    return {s, comb};
  endfunction

  // Single-precision multiply, subnormals kept
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic              s;
    logic [7:0]        ea;
    logic [7:0]        eb;
    logic [23:0]       ma;
    logic [23:0]       mb;
    logic [47:0]       p;
    logic [5:0]        lz;
    logic signed [10:0] e;
    logic              anan, bnan, ainf, binf, azero, bzero;
    s     = a[31] ^ b[31];
    anan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bnan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ainf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    binf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    azero = (a[30:0] == 31'd0);
    bzero = (b[30:0] == 31'd0);
    if (anan || bnan || (ainf && bzero) || (binf && azero)) return QNan;
    if (ainf || binf) return {s, 8'hFF, 23'd0};
    if (azero || bzero) return {s, 31'd0};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    p  = ma * mb;
    lz = fp_lz({p, 2'b00});
    e  = 11'(ea) + 11'(eb) - 11'sd126 - 11'(lz);
    return fp_round(s, e, {p, 2'b00} << lz);
  endfunction

  // Single-precision add, subnormals kept
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]       bg;
    logic [31:0]       sm;
    logic [7:0]        eg;
    logic [7:0]        es;
    logic [7:0]        d;
    logic [99:0]       w;
    logic [49:0]       av;
    logic [49:0]       bv;
    logic [49:0]       sum;
    logic [5:0]        lz;
    logic signed [10:0] e;
    logic              anan, bnan, ainf, binf;
    anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (anan || bnan || (ainf && binf && (a[31] != b[31]))) return QNan;
    if (ainf) return a;
    if (binf) return b;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
    // order by magnitude
    if (a[30:0] < b[30:0]) begin
      bg = b;
      sm = a;
    end else begin
      bg = a;
      sm = b;
    end
    eg = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d  = eg - es;
    if (d > 8'd50) d = 8'd50;
    av  = {1'b0, (bg[30:23] != 8'd0), bg[22:0], 25'd0};
    w   = {1'b0, (sm[30:23] != 8'd0), sm[22:0], 25'd0, 50'd0} >> d;
    bv  = w[99:50] | {49'd0, |w[49:0]};
    sum = (bg[31] != sm[31]) ? av - bv : av + bv;
    if (sum == 50'd0) return 32'd0;
    lz = fp_lz(sum);
    e  = 11'(eg) + 11'sd1 - 11'(lz);
    return fp_round(bg[31], e, sum << lz);
  endfunction

  // Replace any NaN by the canonical quiet NaN
  function automatic logic [31:0] fp_canon(input logic [31:0] v);
    if ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) return QNan;
    return v;
  endfunction

endpackage

>>> src/vec3_normalize_fast_rsqrt_unit.sv
// Vector normalize with fast inverse square root estimate and one Newton step.
// Pipeline: 9 register stages from the input transfer to the result register.
// Throughput: one vector per cycle while out_stall is low; each stage holds one step of the computation.
// Stalls hold only the stages behind a full stage, so bubbles collapse.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module vec3_normalize_fast_rsqrt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  input  logic [31:0] in_z_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x_out,
  output logic [31:0] out_y_out,
  output logic [31:0] out_z_out
);

  localparam int unsigned Ns = v3n_pkg::NumStages;

  v3n_pkg::stg_t        st_r   [Ns];
  v3n_pkg::stg_t        st_nxt [Ns];
  logic [Ns-1:0]        vld_r;
  logic [Ns-1:0]        vld_in;
  logic [Ns:0]          adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[Ns] = !out_stall;
    for (int i = Ns - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  // Valid bit arriving at each stage
  assign vld_in = {vld_r[Ns-2:0], in_valid};

  // Stage datapath: one computation step per stage
  always_comb begin
    for (int i = 0; i < Ns; i++) st_nxt[i] = st_r[i];
    // squares
    st_nxt[0].x = in_x_in;
    st_nxt[0].y = in_y_in;
    st_nxt[0].z = in_z_in;
    st_nxt[0].a = v3n_pkg::fp_mul(in_x_in, in_x_in);
    st_nxt[0].b = v3n_pkg::fp_mul(in_y_in, in_y_in);
    st_nxt[0].c = v3n_pkg::fp_mul(in_z_in, in_z_in);
    st_nxt[0].e = '0;
    // x*x + y*y
    st_nxt[1]   = st_r[0];
    st_nxt[1].a = v3n_pkg::fp_add(st_r[0].a, st_r[0].b);
    // squared length
    st_nxt[2]   = st_r[1];
    st_nxt[2].a = v3n_pkg::fp_add(st_r[1].a, st_r[1].c);
    // half and bit-trick estimate
    st_nxt[3]   = st_r[2];
    st_nxt[3].a = v3n_pkg::fp_mul(st_r[2].a, v3n_pkg::OneHalf);
    st_nxt[3].e = v3n_pkg::RsqrtMagic - {st_r[2].a[31], st_r[2].a[31:1]};
    // half * e
    st_nxt[4]   = st_r[3];
    st_nxt[4].a = v3n_pkg::fp_mul(st_r[3].a, st_r[3].e);
    // (half * e) * e
    st_nxt[5]   = st_r[4];
    st_nxt[5].a = v3n_pkg::fp_mul(st_r[4].a, st_r[4].e);
    // 1.5 - t
    st_nxt[6]   = st_r[5];
    st_nxt[6].a = v3n_pkg::fp_add(v3n_pkg::ThreeHalf, {~st_r[5].a[31], st_r[5].a[30:0]});
    // scale
    st_nxt[7]   = st_r[6];
    st_nxt[7].a = v3n_pkg::fp_mul(st_r[6].e, st_r[6].a);
    // scaled components
    st_nxt[8]   = st_r[7];
    st_nxt[8].a = v3n_pkg::fp_canon(v3n_pkg::fp_mul(st_r[7].x, st_r[7].a));
    st_nxt[8].b = v3n_pkg::fp_canon(v3n_pkg::fp_mul(st_r[7].y, st_r[7].a));
    st_nxt[8].c = v3n_pkg::fp_canon(v3n_pkg::fp_mul(st_r[7].z, st_r[7].a));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < Ns; i++) begin
        if (adv[i]) vld_r[i] <= vld_in[i];
      end
    end
  end

  // Stage data; load only on a valid transfer
  always_ff @(posedge clk) begin
    for (int i = 0; i < Ns; i++) begin
      if (adv[i] && vld_in[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = vld_r[Ns-1];
  assign out_x_out = st_r[Ns-1].a;
  assign out_y_out = st_r[Ns-1].b;
  assign out_z_out = st_r[Ns-1].c;

  // An empty pipeline never stalls its input
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '0) |-> !in_stall) else $error("stall with empty pipeline");

  // A free output lets the whole pipeline move
  a_free_out_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall) else $error("input stalled with free output");

  // An input transfer fills the first stage
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0]) else $error("transfer lost at first stage");

endmodule

>>> tb/tb_checker.sv
module tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  input  logic [31:0] in_z_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_x_out,
  input  logic [31:0] out_y_out,
  input  logic [31:0] out_z_out,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec_t;

  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] Magic    = 32'h5f3759df;
  localparam logic [31:0] Half     = 32'h3F000000;
  localparam logic [31:0] OnePtFive = 32'h3FC00000;

  vec_t unit_q[$];

  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // Split a finite float into an integer significand and a power of two
  function automatic void split_float(input logic [31:0] a, output logic [63:0] m,
                                      output int ex);
    if (a[30:23] == 8'd0) begin
      m  = {41'd0, a[22:0]};
      ex = -149;
    end else begin
      m  = {40'd0, 1'b1, a[22:0]};
      ex = int'(a[30:23]) - 150;
    end
  endfunction

  // Round m * 2^ex to single precision, nearest even
  function automatic logic [31:0] round_pack(logic s, int ex, logic [63:0] m);
    int          msb;
    int          sh;
    int          be;
    logic [127:0] w;
    logic [63:0] q;
    logic [63:0] lo;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) msb = i;
    end
    sh = msb - 23;
    if (-149 - ex > sh) sh = -149 - ex;
    if (sh > 0) begin
      if (sh > 66) sh = 66;
      w  = {m, 64'd0} >> sh;
      q  = w[127:64];
      lo = w[63:0];
      if (lo[63] && ((|lo[62:0]) || q[0])) q = q + 64'd1;
    end else begin
      q = m << (-sh);
    end
    if (q[24]) begin
      q  = q >> 1;
      sh = sh + 1;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    be = ex + sh + 150;
    if (be >= 255) return {s, 8'hFF, 23'd0};
    return {s, be[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] mul_sp(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [63:0] ma;
    logic [63:0] mb;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0)) return CanonNan;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
    split_float(a, ma, ea);
    split_float(b, mb, eb);
    return round_pack(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] add_sp(logic [31:0] a, logic [31:0] b);
    logic [31:0] big;
    logic [31:0] lit;
    logic [63:0] mg;
    logic [63:0] ml;
    logic [63:0] sum;
    int          eg;
    int          el;
    int          d;
    if (is_nan(a) || is_nan(b)) return CanonNan;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CanonNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] < b[30:0]) begin
      big = b;
      lit = a;
    end else begin
      big = a;
      lit = b;
    end
    split_float(big, mg, eg);
    split_float(lit, ml, el);
    d  = eg - el;
    // align both to eg-30; far-off small operand collapses into a sticky bit
    mg = mg << 30;
    if (d <= 30) begin
      ml = ml << (30 - d);
    end else if (d - 30 >= 64) begin
      ml = 64'd1;
    end else begin
      ml = (ml >> (d - 30)) | {63'd0, (ml & ((64'd1 << (d - 30)) - 64'd1)) != 64'd0};
    end
    sum = (big[31] != lit[31]) ? mg - ml : mg + ml;
    if (sum == 64'd0) return 32'd0;
    return round_pack(big[31], eg - 30, sum);
  endfunction

  function automatic logic [31:0] canon(logic [31:0] v);
    return is_nan(v) ? CanonNan : v;
  endfunction

  function automatic vec_t normalize_vec(vec_t v);
    logic [31:0] n;
    logic [31:0] h;
    logic [31:0] est;
    logic [31:0] t;
    logic [31:0] sc;
    vec_t        r;
    n   = add_sp(add_sp(mul_sp(v.x, v.x), mul_sp(v.y, v.y)), mul_sp(v.z, v.z));
    h   = mul_sp(n, Half);
    est = Magic - {n[31], n[31:1]};
    t   = mul_sp(mul_sp(h, est), est);
    sc  = mul_sp(est, add_sp(OnePtFive, {~t[31], t[30:0]}));
    r.x = canon(mul_sp(v.x, sc));
    r.y = canon(mul_sp(v.y, sc));
    r.z = canon(mul_sp(v.z, sc));
    return r;
  endfunction

  assign pending = unit_q.size();

  // Predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    vec_t got;
    vec_t want;
    if (!rst_n) begin
      fails = 0;
    end else begin
      if (in_valid && !in_stall) begin
        got = '{in_x_in, in_y_in, in_z_in};
        unit_q.push_back(normalize_vec(got));
      end
      if (out_valid && !out_stall) begin
        if (unit_q.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fails = fails + 1;
        end else begin
          want = unit_q.pop_front();
          if (out_x_out !== want.x) begin
            $error("x_out: expected %h, got %h", want.x, out_x_out);
            fails = fails + 1;
          end
          if (out_y_out !== want.y) begin
            $error("y_out: expected %h, got %h", want.y, out_y_out);
            fails = fails + 1;
          end
          if (out_z_out !== want.z) begin
            $error("z_out: expected %h, got %h", want.z, out_z_out);
            fails = fails + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_x_in;
  logic [31:0] in_y_in;
  logic [31:0] in_z_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x_out;
  logic [31:0] out_y_out;
  logic [31:0] out_z_out;
  int          fails;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  localparam int WatchdogLimit = 4000;

  always #2 clk = ~clk;

  vec3_normalize_fast_rsqrt_unit DUT (.*);

  tb_checker u_checker (.*);

  // Randomly hold the result channel
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // End the run when transfers stop for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_in  <= x;
    in_y_in  <= y;
    in_z_in  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_component();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return $urandom();
    if (sel < 24) return {1'($urandom_range(1)), 31'd0};
    if (sel < 27) return {1'($urandom_range(1)), 8'hFF, 23'd0};
    if (sel < 30) return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
    if (sel < 34) return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
    if (sel < 38) return {1'($urandom_range(1)), 8'($urandom_range(200, 254)), 23'($urandom())};
    if (sel < 42) return {1'($urandom_range(1)), 8'($urandom_range(1, 50)), 23'($urandom())};
    return {1'($urandom_range(1)), 8'($urandom_range(100, 154)), 23'($urandom())};
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_vec(pick_component(), pick_component(), pick_component());
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_x_in  <= '0;
    in_y_in  <= '0;
    in_z_in  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vectors, unit axes, extremes, infinities, NaNs, subnormals
    send_vec(32'h00000000, 32'h00000000, 32'h00000000);
    send_vec(32'h80000000, 32'h00000000, 32'h80000000);
    send_vec(32'h3F800000, 32'h00000000, 32'h00000000);
    send_vec(32'h00000000, 32'hBF800000, 32'h00000000);
    send_vec(32'h40400000, 32'h40800000, 32'h00000000);
    send_vec(32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF);
    send_vec(32'hFF7FFFFF, 32'h00000000, 32'h3F800000);
    send_vec(32'h7F800000, 32'h00000000, 32'h3F800000);
    send_vec(32'hFF800000, 32'h7F800000, 32'h00000000);
    send_vec(32'h7FC00000, 32'h3F800000, 32'h00000000);
    send_vec(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_vec(32'h7F800001, 32'h00000000, 32'h00000000);
    send_vec(32'h00000001, 32'h00000000, 32'h00000000);
    send_vec(32'h807FFFFF, 32'h007FFFFF, 32'h00000001);
    send_vec(32'h00800000, 32'h80800000, 32'h00800000);
    send_vec(32'h1F800000, 32'h00000000, 32'h00000000);
    send_vec(32'h5F800000, 32'h5F800000, 32'h5F800000);
    send_vec(32'h3F000000, 32'h3F000000, 32'h3F000000);
    send_vec(32'h55555555, 32'hAAAAAAAA, 32'h33333333);

    // Drain fully before the random part
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    run_phase(140, 0, 0);
    run_phase(140, 58, 0);
    run_phase(140, 0, 58);
    run_phase(140, 16, 16);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
src/v3n_pkg.sv
src/vec3_normalize_fast_rsqrt_unit.sv
tb/tb_checker.sv
tb/tb_top.sv
